// File: sv/mahd_pkg.sv
// package for the mpeg audio header decoder: types, tables and lookup functions
package mahd_pkg;

    // decoded version numbers
    localparam logic [1:0] VER_NONE   = 2'd0;
    localparam logic [1:0] VER_MPEG1  = 2'd1;
    localparam logic [1:0] VER_MPEG2  = 2'd2;
    localparam logic [1:0] VER_MPEG25 = 2'd3;

    // raw version codes in the header
    localparam logic [1:0] VCODE_MPEG25   = 2'b00;
    localparam logic [1:0] VCODE_RESERVED = 2'b01;
    localparam logic [1:0] VCODE_MPEG2    = 2'b10;
    localparam logic [1:0] VCODE_MPEG1    = 2'b11;

    // raw layer codes in the header, layer i has the highest code
    localparam logic [1:0] LCODE_RESERVED = 2'b00;
    localparam logic [1:0] LCODE_L3       = 2'b01;
    localparam logic [1:0] LCODE_L2       = 2'b10;
    localparam logic [1:0] LCODE_L1       = 2'b11;

    // decoded layer numbers
    localparam logic [1:0] LAYER_NONE = 2'd0;
    localparam logic [1:0] LAYER_1    = 2'd1;
    localparam logic [1:0] LAYER_2    = 2'd2;
    localparam logic [1:0] LAYER_3    = 2'd3;

    // sample-rate index codes
    localparam logic [1:0] SRI_44K1     = 2'd0;
    localparam logic [1:0] SRI_48K      = 2'd1;
    localparam logic [1:0] SRI_32K      = 2'd2;
    localparam logic [1:0] SRI_RESERVED = 2'd3;

    localparam logic [3:0] BRI_FREE     = 4'd0;
    localparam logic [3:0] BRI_RESERVED = 4'd15;
    localparam logic [1:0] MODE_MONO    = 2'd3;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [2:0] SYNC_HIGH = 3'b111;

    // fixed-point reciprocal: quotient estimate is (y * recip) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 20;
    localparam int Y_W         = 20;
    localparam int RECIP_W     = 21;
    localparam int K_W         = 13;
    localparam int Q_W         = 12;
    localparam int X_W         = K_W + 9;
    localparam int P_W         = Y_W + RECIP_W;

    typedef enum logic [1:0] {
        DIV_ONE,
        DIV_THREE,
        DIV_441
    } div_sel_t;

    typedef struct packed {
        logic        ok;
        logic [1:0]  ver;
        logic [1:0]  layer;
        logic [8:0]  br;
        logic [15:0] sr;
        logic [1:0]  chan;
        logic [10:0] spf;
        logic        pad;
        logic [K_W-1:0] k;
        logic [2:0]  shift;
        div_sel_t    div_sel;
    } dec_t;

    localparam logic [8:0] RATE_V1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [8:0] RATE_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [8:0] RATE_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [8:0] RATE_V2_L1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [8:0] RATE_V2_L23 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    function automatic logic [8:0] bitrate(input logic [1:0] ver, input logic [1:0] layer,
                                           input logic [3:0] bri);
        logic [8:0] r;
        r = 9'd0;
        if (ver == VER_MPEG1) begin
            case (layer)
                LAYER_1: r = RATE_V1_L1[bri];
                LAYER_2: r = RATE_V1_L2[bri];
                LAYER_3: r = RATE_V1_L3[bri];
                default: r = 9'd0;
            endcase
        end else if (layer == LAYER_1) begin
            r = RATE_V2_L1[bri];
        end else begin
            r = RATE_V2_L23[bri];
        end
        return r;
    endfunction

    function automatic logic [RECIP_W-1:0] recip(input div_sel_t sel);
        logic [RECIP_W-1:0] m;
        case (sel)
            DIV_ONE:   m = RECIP_W'(1 << RECIP_SHIFT);
            DIV_THREE: m = RECIP_W'((1 << RECIP_SHIFT) / 3);
            DIV_441:   m = RECIP_W'((1 << RECIP_SHIFT) / 441);
            default:   m = RECIP_W'(1 << RECIP_SHIFT);
        endcase
        return m;
    endfunction

    function automatic logic [8:0] divisor(input div_sel_t sel);
        logic [8:0] d;
        case (sel)
            DIV_ONE:   d = 9'd1;
            DIV_THREE: d = 9'd3;
            DIV_441:   d = 9'd441;
            default:   d = 9'd1;
        endcase
        return d;
    endfunction

endpackage

// File: sv/mpeg_audio_header_decode_top.sv
// top level of the mpeg audio frame header decoder pipeline
//
// input channel (s_): one 32-bit header word, first byte in the top bits, and
// a flag for a header with fewer than four bytes present. output channel (m_):
// the decoded fields; m_valid_res is low and all other fields zero when the
// header fails any check (sync, reserved version/layer/rate, free format).
// four register stages:
//   s1  field checks and table lookups (bitrate, sample rate, scale factors)
//   s2  numerator multiply, bitrate times a per-format constant, then shift
//   s3  quotient estimate by multiplying with a fixed-point reciprocal
//   out remainder check that corrects the quotient by one, padding, layer i
//       slot scaling; this is the output register
// m_valid rises when the item is loaded into the output register after s1, s2 and s3;
// one item per cycle sustained while m_ready stays high.
// each stage has its own valid bit and advances when it is empty or the next
// stage advances, so a stalled receiver backs up only full stages and s_ready
// stays high while bubbles remain. no item is dropped or repeated on a stall.
// reset (aresetn low, synchronous) empties every stage; the payload registers are not reset.
module mpeg_audio_header_decode_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_header_word,
    input  logic        s_short_input,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [1:0]  m_mpeg_version,
    output logic [1:0]  m_layer_number,
    output logic [8:0]  m_bitrate_kbps,
    output logic [15:0] m_sample_rate_hz,
    output logic [1:0]  m_channel_count,
    output logic [10:0] m_frame_samples,
    output logic [11:0] m_frame_bytes
);

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic en1, en2, en3, eno;

    // per-stage payload
    mahd_pkg::dec_t dec1_next, dec1_reg, dec2_reg, dec3_reg;
    logic [mahd_pkg::Y_W-1:0] y2_next, y2_reg, y3_reg;
    logic [mahd_pkg::Q_W-1:0] q3_next, q3_reg;
    logic [11:0] size_next, size_reg;

    logic [mahd_pkg::X_W-1:0] num;
    logic [mahd_pkg::P_W-1:0] prod;
    logic [8:0]     dv;
    logic [20:0]    qd;
    logic [mahd_pkg::Y_W-1:0] rem;
    logic [mahd_pkg::Q_W-1:0] q_fix;
    logic [12:0]    slots;

    // stall chain: a stage loads when empty or when its successor moves on
    assign eno     = !vo_reg || m_ready;
    assign en3     = !v3_reg || eno;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    mahd_field_decode u_decode (
        .header_word (s_header_word),
        .short_input (s_short_input),
        .dec         (dec1_next)
    );

    // s2: bitrate times (coef * 1000/sr numerator), then the power-of-two part of the divisor
    always_comb begin
        num     = mahd_pkg::X_W'(dec1_reg.br) * mahd_pkg::X_W'(dec1_reg.k);
        y2_next = mahd_pkg::Y_W'(num >> dec1_reg.shift);
    end

    // s3: estimate is exact or one low
    always_comb begin
        prod    = mahd_pkg::P_W'(y2_reg) * mahd_pkg::P_W'(mahd_pkg::recip(dec2_reg.div_sel));
        q3_next = prod[mahd_pkg::RECIP_SHIFT +: mahd_pkg::Q_W];
    end

    // out: remainder check, padding, layer i works in 4-byte slots
    always_comb begin
        dv    = mahd_pkg::divisor(dec3_reg.div_sel);
        qd    = 21'(q3_reg) * 21'(dv);
        rem   = y3_reg - mahd_pkg::Y_W'(qd);
        q_fix = q3_reg + ((rem >= mahd_pkg::Y_W'(dv)) ? 12'd1 : 12'd0);
        slots = 13'(q_fix) + 13'(dec3_reg.pad);
        if (dec3_reg.layer == mahd_pkg::LAYER_1)
            size_next = 12'(slots << 2);
        else
            size_next = slots[11:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (eno) vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            dec1_reg <= dec1_next;
        end
        if (en2) begin
            dec2_reg <= dec1_reg;
            y2_reg   <= y2_next;
        end
        if (en3) begin
            dec3_reg <= dec2_reg;
            y3_reg   <= y2_reg;
            q3_reg   <= q3_next;
        end
    end

    mahd_pkg::dec_t deco_reg;

    always_ff @(posedge aclk) begin
        if (eno) begin
            deco_reg <= dec3_reg;
            size_reg <= size_next;
        end
    end

    assign m_valid          = vo_reg;
    assign m_valid_res      = deco_reg.ok;
    assign m_mpeg_version   = deco_reg.ver;
    assign m_layer_number   = deco_reg.layer;
    assign m_bitrate_kbps   = deco_reg.br;
    assign m_sample_rate_hz = deco_reg.sr;
    assign m_channel_count  = deco_reg.chan;
    assign m_frame_samples  = deco_reg.spf;
    assign m_frame_bytes    = size_reg;

endmodule

// File: sv/mahd_field_decode.sv
// header field checks and table lookups for the first pipeline stage
module mahd_field_decode (
    input  logic [31:0]   header_word,
    input  logic          short_input,
    output mahd_pkg::dec_t dec
);

    logic [7:0]  b0, b1, b2, b3;
    logic [1:0]  ver, layer, sri, mode;
    logic [3:0]  bri;
    logic        ok;
    logic [15:0] sr_base;
    logic [1:0]  vshift;
    logic [7:0]  coef;
    logic [5:0]  pmul;
    logic [2:0]  tshift;
    mahd_pkg::div_sel_t dsel;

    assign b0   = header_word[31:24];
    assign b1   = header_word[23:16];
    assign b2   = header_word[15:8];
    assign b3   = header_word[7:0];
    assign bri  = b2[7:4];
    assign sri  = b2[3:2];
    assign mode = b3[7:6];

    always_comb begin
        case (b1[4:3])
            mahd_pkg::VCODE_MPEG25:   ver = mahd_pkg::VER_MPEG25;
            mahd_pkg::VCODE_RESERVED: ver = mahd_pkg::VER_NONE;
            mahd_pkg::VCODE_MPEG2:    ver = mahd_pkg::VER_MPEG2;
            mahd_pkg::VCODE_MPEG1:    ver = mahd_pkg::VER_MPEG1;
            default:                  ver = mahd_pkg::VER_NONE;
        endcase
        // layer code counts down: 11 is layer 1, 00 is reserved
        layer = (b1[2:1] == mahd_pkg::LCODE_RESERVED) ? mahd_pkg::LAYER_NONE
                                                      : 2'(3'd4 - {1'b0, b1[2:1]});
    end

    assign ok = !short_input && (b0 == mahd_pkg::SYNC_BYTE)
             && (b1[7:5] == mahd_pkg::SYNC_HIGH)
             && (ver != mahd_pkg::VER_NONE) && (layer != mahd_pkg::LAYER_NONE)
             && (sri != mahd_pkg::SRI_RESERVED)
             && (bri != mahd_pkg::BRI_FREE) && (bri != mahd_pkg::BRI_RESERVED);

    always_comb begin
        case (ver)
            mahd_pkg::VER_MPEG2:  vshift = 2'd1;
            mahd_pkg::VER_MPEG25: vshift = 2'd2;
            default:              vshift = 2'd0;
        endcase

        // 1000/sr reduces to pmul / (d << tshift)
        case (sri)
            mahd_pkg::SRI_44K1: begin
                sr_base = 16'd44100;
                pmul    = 6'(6'd10 << vshift);
                tshift  = 3'd0;
                dsel    = mahd_pkg::DIV_441;
            end
            mahd_pkg::SRI_48K: begin
                sr_base = 16'd48000;
                pmul    = 6'd1;
                tshift  = 3'(3'd4 - {1'b0, vshift});
                dsel    = mahd_pkg::DIV_THREE;
            end
            mahd_pkg::SRI_32K: begin
                sr_base = 16'd32000;
                pmul    = 6'd1;
                tshift  = 3'(3'd5 - {1'b0, vshift});
                dsel    = mahd_pkg::DIV_ONE;
            end
            default: begin
                sr_base = 16'd0;
                pmul    = 6'd0;
                tshift  = 3'd0;
                dsel    = mahd_pkg::DIV_ONE;
            end
        endcase

        if (layer == mahd_pkg::LAYER_1)
            coef = 8'd12;
        else if (layer == mahd_pkg::LAYER_2 || ver == mahd_pkg::VER_MPEG1)
            coef = 8'd144;
        else
            coef = 8'd72;
    end

    always_comb begin
        dec = '0;
        dec.div_sel = mahd_pkg::DIV_ONE;
        if (ok) begin
            dec.ok      = 1'b1;
            dec.ver     = ver;
            dec.layer   = layer;
            dec.br      = mahd_pkg::bitrate(ver, layer, bri);
            dec.sr      = sr_base >> vshift;
            dec.chan    = (mode == mahd_pkg::MODE_MONO) ? 2'd1 : 2'd2;
            dec.pad     = b2[1];
            dec.k       = mahd_pkg::K_W'(coef) * mahd_pkg::K_W'(pmul);
            dec.shift   = tshift;
            dec.div_sel = dsel;
            if (layer == mahd_pkg::LAYER_1)
                dec.spf = 11'd384;
            else if (layer == mahd_pkg::LAYER_2 || ver == mahd_pkg::VER_MPEG1)
                dec.spf = 11'd1152;
            else
                dec.spf = 11'd576;
        end
    end

endmodule
